[hdl/crt_pkg.sv]
// ---------------------------------------------------------------------------
// crt_pkg: shared constants and types for the chunk reassembly tracker
// Holds register indexes, reset values, field widths and the command and
// status structs passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package crt_pkg;

	// Table depth default and the header length of a chunk
	localparam int MAX_PARTS_DEF = 64;
	localparam int CHUNK_HDR     = 4;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int IDXF_W   = 16;
	localparam int TIME_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int OFS_W    = 3;
	localparam int PART_W   = 6;
	localparam int ENTRY_W  = HANDLE_W + LEN_W;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_MARKER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MORE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [BYTE_W-1:0] MARKER_RST  = 8'd0;
	localparam logic [BYTE_W-1:0] MORE_RST    = 8'd1;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;

	// Result kinds
	localparam logic KIND_PLAIN = 1'b0;
	localparam logic KIND_CHUNK = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;       // capture the input item
		logic store;      // store the captured chunk, restarting on timeout
		logic clear;      // drop any reassembly in progress
		logic plain_out;  // present the captured item as a plain result
		logic rd;         // read the table entry of the current part
		logic send;       // present the read entry and advance the part
	} crt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_chunk;   // captured item carries the chunk marker and a full header
		logic in_range;   // captured chunk index fits the table
		logic complete;   // all parts up to the expected count are present
		logic last;       // current part is the final one
	} crt_sts_t;

endpackage

[hdl/crt_ram.sv]
// ---------------------------------------------------------------------------
// crt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module crt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write, and read into a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/crt_ctrl.sv]
// ---------------------------------------------------------------------------
// crt_ctrl: sequencing controller of the chunk reassembly tracker
// Classifies each item, stores in-range chunks and walks the table on completion.
// ---------------------------------------------------------------------------
module crt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  crt_pkg::crt_sts_t sts,
	output crt_pkg::crt_cmd_t cmd
);
	import crt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_SEND  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Decide the next state and the datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!sts.is_chunk) begin
					cmd.plain_out = 1'b1;
					cmd.clear     = 1'b1;
					state_d       = ST_IDLE;
				end else if (!sts.in_range) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cmd.store = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sts.complete ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_SEND;
			end
			ST_SEND: begin
				cmd.send = 1'b1;
				if (sts.last) begin
					cmd.clear = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hdl/crt_datapath.sv]
// ---------------------------------------------------------------------------
// crt_datapath: registers, tables and result path of the tracker
// Holds configuration, the captured item, the presence map, the part table
// and the result registers.
// ---------------------------------------------------------------------------
module crt_datapath #(
	parameter int MAX_PARTS = crt_pkg::MAX_PARTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [crt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [crt_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [crt_pkg::BYTE_W-1:0]        first_byte,
	input  logic [crt_pkg::LEN_W-1:0]         message_length,
	input  logic [crt_pkg::IDXF_W-1:0]        chunk_index,
	input  logic [crt_pkg::BYTE_W-1:0]        flag_bits,
	input  logic [crt_pkg::TIME_W-1:0]        now_ms,
	input  logic [crt_pkg::HANDLE_W-1:0]      message_handle,
	input  crt_pkg::crt_cmd_t                 cmd,
	output crt_pkg::crt_sts_t                 sts,
	output logic                              result_valid,
	output logic                              kind,
	output logic [crt_pkg::HANDLE_W-1:0]      out_handle,
	output logic [crt_pkg::OFS_W-1:0]         payload_offset,
	output logic [crt_pkg::LEN_W-1:0]         payload_length,
	output logic [crt_pkg::PART_W-1:0]        part_number,
	output logic                              last_part
);
	import crt_pkg::*;

	localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int CNT_W = $clog2(MAX_PARTS + 1);

	// Configuration registers
	logic [BYTE_W-1:0] marker_q;
	logic [BYTE_W-1:0] more_mask_q;
	logic [TIME_W-1:0] timeout_q;

	// Captured item
	logic [BYTE_W-1:0]   first_q;
	logic [LEN_W-1:0]    mlen_q;
	logic [IDXF_W-1:0]   idx_q;
	logic [BYTE_W-1:0]   flags_q;
	logic [TIME_W-1:0]   now_q;
	logic [HANDLE_W-1:0] handle_q;

	// Reassembly state
	logic [MAX_PARTS-1:0] present_q;
	logic [CNT_W-1:0]     count_q;
	logic                 receiving_q;
	logic [TIME_W-1:0]    start_q;
	logic [IDX_W-1:0]     part_q;

	// Result registers
	logic                result_valid_q;
	logic                kind_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [OFS_W-1:0]    offset_q;
	logic [LEN_W-1:0]    plen_q;
	logic [PART_W-1:0]   part_num_q;
	logic                last_q;

	logic [IDX_W-1:0]     wr_idx;
	logic [TIME_W-1:0]    elapsed;
	logic                 timed_out;
	logic [MAX_PARTS-1:0] low_mask;
	logic [ENTRY_W-1:0]   wr_entry;
	logic [ENTRY_W-1:0]   rd_entry;

	assign wr_idx    = idx_q[IDX_W-1:0];
	assign elapsed   = now_q - start_q;
	assign timed_out = receiving_q && (elapsed > timeout_q);
	assign wr_entry  = {handle_q, mlen_q - LEN_W'(CHUNK_HDR)};

	// Thermometer mask of the parts below the expected count
	always_comb begin
		for (int i = 0; i < MAX_PARTS; i++) begin
			low_mask[i] = (CNT_W'(i) < count_q);
		end
	end

	// Status towards the controller
	assign sts.is_chunk = (mlen_q >= LEN_W'(CHUNK_HDR)) && (first_q == marker_q);
	assign sts.in_range = (idx_q < IDXF_W'(MAX_PARTS));
	assign sts.complete = (count_q != '0) && (&(present_q | ~low_mask));
	assign sts.last     = ((CNT_W'(part_q) + CNT_W'(1)) == count_q);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q    <= MARKER_RST;
			more_mask_q <= MORE_RST;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MARKER:  marker_q    <= cfg_data[BYTE_W-1:0];
				CFG_MORE:    more_mask_q <= cfg_data[BYTE_W-1:0];
				CFG_TIMEOUT: timeout_q   <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q  <= first_byte;
			mlen_q   <= message_length;
			idx_q    <= chunk_index;
			flags_q  <= flag_bits;
			now_q    <= now_ms;
			handle_q <= message_handle;
		end
	end

	// Update the presence map, count and timer; restart on timeout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			count_q     <= '0;
			receiving_q <= 1'b0;
			start_q     <= '0;
		end else if (cmd.clear) begin
			present_q   <= '0;
			count_q     <= '0;
			receiving_q <= 1'b0;
			start_q     <= '0;
		end else if (cmd.store) begin
			present_q   <= (timed_out ? '0 : present_q) | (MAX_PARTS'(1) << wr_idx);
			receiving_q <= 1'b1;
			if (!receiving_q || timed_out) begin
				start_q <= now_q;
			end
			if ((flags_q & more_mask_q) == '0) begin
				count_q <= CNT_W'(wr_idx) + CNT_W'(1);
			end else if (timed_out) begin
				count_q <= '0;
			end
		end
	end

	// Advance the part counter during delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
		end else if (cmd.store) begin
			part_q <= '0;
		end else if (cmd.send) begin
			part_q <= part_q + IDX_W'(1);
		end
	end

	// Part table: handle and payload length per index
	crt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_PARTS)
	) u_table (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(wr_idx),
		.wdata(wr_entry),
		.re   (cmd.rd),
		.raddr(part_q),
		.rdata(rd_entry)
	);

	// Strobe for one cycle per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.plain_out || cmd.send;
		end
	end

	// Load result fields
	always_ff @(posedge clk) begin
		if (cmd.plain_out) begin
			kind_q       <= KIND_PLAIN;
			out_handle_q <= handle_q;
			offset_q     <= '0;
			plen_q       <= mlen_q;
			part_num_q   <= '0;
			last_q       <= 1'b1;
		end else if (cmd.send) begin
			kind_q       <= KIND_CHUNK;
			out_handle_q <= rd_entry[ENTRY_W-1:LEN_W];
			offset_q     <= OFS_W'(CHUNK_HDR);
			plen_q       <= rd_entry[LEN_W-1:0];
			part_num_q   <= PART_W'(part_q);
			last_q       <= sts.last;
		end
	end

	assign result_valid   = result_valid_q;
	assign kind           = kind_q;
	assign out_handle     = out_handle_q;
	assign payload_offset = offset_q;
	assign payload_length = plen_q;
	assign part_number    = part_num_q;
	assign last_part      = last_q;

	// A clear leaves no part marked present
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (present_q == '0))
		else $error("presence map not empty after clear");

	// Parts are only marked while a reassembly is running
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!receiving_q |-> (present_q == '0))
		else $error("part present with no reassembly running");

	// Delivery never walks past the expected count
	a_send_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.send |-> (CNT_W'(part_q) < count_q))
		else $error("part delivered beyond expected count");

	// The final chunk result coincides with the end of the reassembly
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && kind_q && last_q) |-> !receiving_q)
		else $error("reassembly still running after final part");

endmodule

[hdl/chunk_reassembly_tracker.sv]
// ---------------------------------------------------------------------------
// chunk_reassembly_tracker: reassembles chunked messages from descriptors
// Plain messages pass straight through; chunks are stored per index and,
// once all parts are present, delivered as one descriptor per part.
// ---------------------------------------------------------------------------
// Plain item: start loads the captured item and the EVAL state registers its result.
// Busy: high through EVAL for a plain item or an out-of-range chunk, through EVAL
// and CHECK for a stored chunk, and for a completing chunk also through a READ and
// SEND pass per part, set by the single-read-port part table read once per part.
// Reset: arst_n clears configuration to defaults and drops any reassembly;
// the part table is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module chunk_reassembly_tracker #(
	parameter int MAX_PARTS = crt_pkg::MAX_PARTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [crt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [crt_pkg::BYTE_W-1:0]     first_byte,
	input  logic [crt_pkg::LEN_W-1:0]      message_length,
	input  logic [crt_pkg::IDXF_W-1:0]     chunk_index,
	input  logic [crt_pkg::BYTE_W-1:0]     flag_bits,
	input  logic [crt_pkg::TIME_W-1:0]     now_ms,
	input  logic [crt_pkg::HANDLE_W-1:0]   message_handle,
	output logic                           result_valid,
	output logic                           kind,
	output logic [crt_pkg::HANDLE_W-1:0]   out_handle,
	output logic [crt_pkg::OFS_W-1:0]      payload_offset,
	output logic [crt_pkg::LEN_W-1:0]      payload_length,
	output logic [crt_pkg::PART_W-1:0]     part_number,
	output logic                           last_part
);
	import crt_pkg::*;

	crt_cmd_t cmd;
	crt_sts_t sts;

	// Sequence each item
	crt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	// Hold state, tables and results
	crt_datapath #(
		.MAX_PARTS(MAX_PARTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.first_byte    (first_byte),
		.message_length(message_length),
		.chunk_index   (chunk_index),
		.flag_bits     (flag_bits),
		.now_ms        (now_ms),
		.message_handle(message_handle),
		.cmd           (cmd),
		.sts           (sts),
		.result_valid  (result_valid),
		.kind          (kind),
		.out_handle    (out_handle),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.part_number   (part_number),
		.last_part     (last_part)
	);

endmodule
